### design/plsf_pkg.sv
// ----------------------------------------------------------------------------
// plsf_pkg
// shared types, sizes and saturating helpers for the polynomial fit block
// ----------------------------------------------------------------------------
package plsf_pkg;

    localparam int MAX_ORDER  = 3;
    localparam int MAX_POINTS = 1024;
    localparam int NPOW       = 2 * MAX_ORDER + 1;
    localparam int NROW       = MAX_ORDER + 1;
    localparam int NCOL       = MAX_ORDER + 2;
    localparam int ROW_W      = 2;
    localparam int COL_W      = 3;
    localparam int POW_W      = 3;
    localparam int CNT_W      = 11;
    localparam int ORD_W      = 2;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int DIV_STEPS  = 96;
    localparam int DSTEP_W    = 7;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic               last_point;
    } sample_t;

    typedef struct packed {
        logic [1:0]         coef_index;
        logic signed [63:0] coefficient;
        logic               singular;
        logic               last_coef;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg);
        if (neg)
            return m[63] ? 64'h8000_0000_0000_0000 : (~m + 64'd1);
        return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

endpackage

### design/polynomial_least_squares_fit.sv
// an ordinary point is accepted, then its powers of x are summed in S_ACC_A, S_ACC_B, S_ACC_C;
// a marked point adds the solve: build, pivot search, elimination and back substitution,
// cut short when a zero pivot stops it, its work mostly in the 96-step serial divider
// and the four-pass 32x32 multiply; then n+1 transfers
// one point at a time: sample_stall is high while a point, a solve or its results are in work
// reset clears sums, count and control; order_reg resets to 1; work matrix is not cleared
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit
// fixed-point polynomial least-squares fit by the normal equations
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  plsf_pkg::sample_t               sample_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output plsf_pkg::result_t               result_data,
    input  logic                            cfg_wr_en,
    input  logic [plsf_pkg::ORD_W-1:0]      cfg_wr_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ACC_A   = 5'd1;
    localparam logic [4:0] S_ACC_B   = 5'd2;
    localparam logic [4:0] S_ACC_C   = 5'd3;
    localparam logic [4:0] S_BUILD   = 5'd4;
    localparam logic [4:0] S_PIV     = 5'd5;
    localparam logic [4:0] S_PIVCHK  = 5'd6;
    localparam logic [4:0] S_ELIM_P  = 5'd7;
    localparam logic [4:0] S_ELIM_D  = 5'd8;
    localparam logic [4:0] S_ELIM_W  = 5'd9;
    localparam logic [4:0] S_QM_LD   = 5'd10;
    localparam logic [4:0] S_ELIM_WR = 5'd11;
    localparam logic [4:0] S_QM      = 5'd12;
    localparam logic [4:0] S_QM_F    = 5'd13;
    localparam logic [4:0] S_BS_S    = 5'd14;
    localparam logic [4:0] S_BS_QM   = 5'd15;
    localparam logic [4:0] S_BS_SUB  = 5'd16;
    localparam logic [4:0] S_BS_DP   = 5'd17;
    localparam logic [4:0] S_BS_W    = 5'd18;
    localparam logic [4:0] S_OUT     = 5'd19;

    localparam int ROW_W = plsf_pkg::ROW_W;
    localparam int COL_W = plsf_pkg::COL_W;
    localparam int POW_W = plsf_pkg::POW_W;
    localparam int CNT_W = plsf_pkg::CNT_W;
    localparam int ORD_W = plsf_pkg::ORD_W;
    localparam int MUL_W = plsf_pkg::MUL_W;

    logic [4:0]             state_reg, state_next;
    logic [4:0]             ret_reg, ret_next;
    logic [ORD_W-1:0]       order_reg, order_next;
    logic [63:0]            psum_reg [plsf_pkg::NPOW];
    logic [63:0]            psum_next [plsf_pkg::NPOW];
    logic [63:0]            msum_reg [plsf_pkg::NROW];
    logic [63:0]            msum_next [plsf_pkg::NROW];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ROW_W-1:0]       perm_reg [plsf_pkg::NROW];
    logic [ROW_W-1:0]       perm_next [plsf_pkg::NROW];
    logic [63:0]            mat_reg [plsf_pkg::NROW][plsf_pkg::NCOL];
    logic [63:0]            coef_reg [plsf_pkg::NROW];
    logic signed [15:0]     x_reg, x_next;
    logic signed [15:0]     y_reg, y_next;
    logic                   last_reg, last_next;
    logic signed [MUL_W-1:0] p_reg, p_next;
    logic [POW_W-1:0]       k_reg, k_next;
    logic [ROW_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       j_reg, j_next;
    logic [ROW_W-1:0]       best_reg, best_next;
    logic [63:0]            bmag_reg, bmag_next;
    logic [63:0]            dvb_reg, dvb_next;
    logic [63:0]            f_reg, f_next;
    logic [63:0]            s_reg, s_next;
    logic [63:0]            ma_reg, ma_next;
    logic [63:0]            mb_reg, mb_next;
    logic                   qneg_reg, qneg_next;
    logic [127:0]           acc_reg, acc_next;
    logic [2:0]             qstep_reg, qstep_next;
    logic [63:0]            qres_reg, qres_next;
    logic                   sing_reg, sing_next;
    logic [ROW_W-1:0]       oidx_reg, oidx_next;

    logic [ORD_W-1:0]       n;
    logic [COL_W-1:0]       ncol_last;
    logic [ROW_W-1:0]       rd_row;
    logic [COL_W-1:0]       rd_col;
    logic [63:0]            rd_data;
    logic                   mat_we;
    logic [ROW_W-1:0]       wr_row;
    logic [COL_W-1:0]       wr_col;
    logic [63:0]            wr_data;
    logic                   coef_we;
    logic                   coef_clr;
    logic                   clr_sums;
    logic                   go_build;
    logic                   qm_start;
    logic [63:0]            qm_a, qm_b;
    logic [4:0]             qm_ret;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [plsf_pkg::PROD_W-1:0] prod;
    logic                   div_start;
    logic [63:0]            div_a, div_b;
    plsf_pkg::div_stat_t    div_stat;
    logic [63:0]            div_quot;
    logic [63:0]            p_ext;
    logic [63:0]            round_tmp;
    logic [63:0]            mag_rd;
    logic [63:0]            qm_mag;
    logic                   accept;

    plsf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    plsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign n = (order_reg > ORD_W'(plsf_pkg::MAX_ORDER)) ? ORD_W'(plsf_pkg::MAX_ORDER)
                                                         : order_reg;
    assign ncol_last    = COL_W'(n) + 1'b1;
    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign rd_data      = mat_reg[perm_reg[rd_row]][rd_col];
    assign mag_rd       = plsf_pkg::mag64(rd_data);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        order_next = cfg_wr_en ? cfg_wr_data : order_reg;
        psum_next  = psum_reg;
        msum_next  = msum_reg;
        count_next = count_reg;
        perm_next  = perm_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        last_next  = last_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        best_next  = best_reg;
        bmag_next  = bmag_reg;
        dvb_next   = dvb_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        qneg_next  = qneg_reg;
        acc_next   = acc_reg;
        qstep_next = qstep_reg;
        qres_next  = qres_reg;
        sing_next  = sing_reg;
        oidx_next  = oidx_reg;
        rd_row     = row_reg;
        rd_col     = j_reg;
        mat_we     = 1'b0;
        wr_row     = perm_reg[row_reg];
        wr_col     = j_reg;
        wr_data    = '0;
        coef_we    = 1'b0;
        coef_clr   = 1'b0;
        clr_sums   = 1'b0;
        go_build   = 1'b0;
        qm_start   = 1'b0;
        qm_a       = '0;
        qm_b       = '0;
        qm_ret     = S_IDLE;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        p_ext      = 64'(p_reg);
        round_tmp  = prod[63:0] + 64'd4096;
        qm_mag     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next    = sample_data.x_value;
                    y_next    = sample_data.y_value;
                    last_next = sample_data.last_point;
                    if (count_reg < CNT_W'(plsf_pkg::MAX_POINTS))
                    begin
                        p_next     = MUL_W'(8192);
                        k_next     = '0;
                        state_next = S_ACC_A;
                    end
                    else if (sample_data.last_point)
                    begin
                        go_build = 1'b1;
                    end
                end
            end
            S_ACC_A:
            begin
                psum_next[k_reg] = plsf_pkg::sat_add(psum_reg[k_reg], p_ext << 19);
                mul_a = MUL_W'(y_reg);
                mul_b = p_reg;
                if (k_reg == POW_W'(plsf_pkg::NPOW - 1))
                begin
                    count_next = count_reg + 1'b1;
                    if (last_reg)
                        go_build = 1'b1;
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ACC_B;
                end
            end
            S_ACC_B:
            begin
                if (k_reg <= POW_W'(plsf_pkg::MAX_ORDER))
                    msum_next[k_reg[ROW_W-1:0]] =
                        plsf_pkg::sat_add(msum_reg[k_reg[ROW_W-1:0]], prod[63:0] << 11);
                mul_a      = p_reg;
                mul_b      = MUL_W'(x_reg);
                state_next = S_ACC_C;
            end
            S_ACC_C:
            begin
                p_next     = MUL_W'($signed(round_tmp) >>> 13);
                k_next     = k_reg + 1'b1;
                state_next = S_ACC_A;
            end
            S_BUILD:
            begin
                mat_we  = 1'b1;
                wr_data = (j_reg <= COL_W'(n))
                          ? psum_reg[POW_W'(row_reg) + POW_W'(j_reg)]
                          : msum_reg[row_reg];
                if (j_reg == ncol_last)
                begin
                    j_next = '0;
                    if (row_reg == n)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        best_next  = '0;
                        bmag_next  = '0;
                        state_next = S_PIV;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_PIV:
            begin
                rd_col = COL_W'(col_reg);
                // strict compare keeps the upper row on a tie
                if (mag_rd > bmag_reg)
                begin
                    best_next = row_reg;
                    bmag_next = mag_rd;
                end
                if (row_reg == n)
                    state_next = S_PIVCHK;
                else
                    row_next = row_reg + 1'b1;
            end
            S_PIVCHK:
            begin
                if (bmag_reg == '0)
                begin
                    sing_next  = 1'b1;
                    clr_sums   = 1'b1;
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    perm_next[col_reg]  = perm_reg[best_reg];
                    perm_next[best_reg] = perm_reg[col_reg];
                    if (col_reg == n)
                    begin
                        row_next   = n;
                        state_next = S_BS_S;
                    end
                    else
                    begin
                        row_next   = col_reg + 1'b1;
                        state_next = S_ELIM_P;
                    end
                end
            end
            S_ELIM_P:
            begin
                rd_row     = col_reg;
                rd_col     = COL_W'(col_reg);
                dvb_next   = rd_data;
                state_next = S_ELIM_D;
            end
            S_ELIM_D:
            begin
                rd_col     = COL_W'(col_reg);
                div_start  = 1'b1;
                div_a      = rd_data;
                div_b      = dvb_reg;
                state_next = S_ELIM_W;
            end
            S_ELIM_W:
            begin
                if (div_stat.done)
                begin
                    f_next     = div_quot;
                    j_next     = COL_W'(col_reg) + 1'b1;
                    state_next = S_QM_LD;
                end
            end
            S_QM_LD:
            begin
                rd_row   = col_reg;
                qm_start = 1'b1;
                qm_a     = f_reg;
                qm_b     = rd_data;
                qm_ret   = S_ELIM_WR;
            end
            S_ELIM_WR:
            begin
                mat_we  = 1'b1;
                wr_data = plsf_pkg::sat_sub(rd_data, qres_reg);
                if (j_reg == ncol_last)
                begin
                    if (row_reg == n)
                    begin
                        col_next   = col_reg + 1'b1;
                        row_next   = col_reg + 1'b1;
                        best_next  = col_reg + 1'b1;
                        bmag_next  = '0;
                        state_next = S_PIV;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_ELIM_P;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_QM_LD;
                end
            end
            S_QM:
            begin
                // four partial products of the magnitudes, low halves first
                mul_a = MUL_W'(qstep_reg[1] ? ma_reg[63:32] : ma_reg[31:0]);
                mul_b = MUL_W'(qstep_reg[0] ? mb_reg[63:32] : mb_reg[31:0]);
                if (qstep_reg != 3'd0)
                begin
                    case (qstep_reg)
                        3'd1:    acc_next = acc_reg + {64'd0, prod[63:0]};
                        3'd4:    acc_next = acc_reg + {prod[63:0], 64'd0};
                        default: acc_next = acc_reg + {32'd0, prod[63:0], 32'd0};
                    endcase
                end
                if (qstep_reg == 3'd4)
                    state_next = S_QM_F;
                else
                    qstep_next = qstep_reg + 1'b1;
            end
            S_QM_F:
            begin
                // rounding half was preloaded into the accumulator
                qm_mag     = (acc_reg[127:96] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                      : acc_reg[95:32];
                qres_next  = plsf_pkg::from_mag(qm_mag, qneg_reg);
                state_next = ret_reg;
            end
            S_BS_S:
            begin
                rd_col = ncol_last;
                s_next = rd_data;
                j_next = COL_W'(row_reg) + 1'b1;
                if (row_reg == n)
                    state_next = S_BS_DP;
                else
                    state_next = S_BS_QM;
            end
            S_BS_QM:
            begin
                qm_start = 1'b1;
                qm_a     = rd_data;
                qm_b     = coef_reg[j_reg[ROW_W-1:0]];
                qm_ret   = S_BS_SUB;
            end
            S_BS_SUB:
            begin
                s_next = plsf_pkg::sat_sub(s_reg, qres_reg);
                if (j_reg == COL_W'(n))
                    state_next = S_BS_DP;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_BS_QM;
                end
            end
            S_BS_DP:
            begin
                rd_col     = COL_W'(row_reg);
                div_start  = 1'b1;
                div_a      = s_reg;
                div_b      = rd_data;
                state_next = S_BS_W;
            end
            S_BS_W:
            begin
                if (div_stat.done)
                begin
                    coef_we = 1'b1;
                    if (row_reg == '0)
                    begin
                        clr_sums   = 1'b1;
                        oidx_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        row_next   = row_reg - 1'b1;
                        state_next = S_BS_S;
                    end
                end
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    if (oidx_reg == n)
                        state_next = S_IDLE;
                    else
                        oidx_next = oidx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (qm_start)
        begin
            ma_next    = plsf_pkg::mag64(qm_a);
            mb_next    = plsf_pkg::mag64(qm_b);
            qneg_next  = qm_a[63] ^ qm_b[63];
            acc_next   = 128'h8000_0000;
            qstep_next = '0;
            ret_next   = qm_ret;
            state_next = S_QM;
        end

        if (go_build)
        begin
            row_next   = '0;
            j_next     = '0;
            sing_next  = 1'b0;
            coef_clr   = 1'b1;
            for (int i = 0; i < plsf_pkg::NROW; i++)
                perm_next[i] = ROW_W'(i);
            state_next = S_BUILD;
        end

        if (clr_sums)
        begin
            for (int i = 0; i < plsf_pkg::NPOW; i++)
                psum_next[i] = '0;
            for (int i = 0; i < plsf_pkg::NROW; i++)
                msum_next[i] = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            order_reg <= ORD_W'(1);
            count_reg <= '0;
            qstep_reg <= '0;
            sing_reg  <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < plsf_pkg::NPOW; i++)
                psum_reg[i] <= '0;
            for (int i = 0; i < plsf_pkg::NROW; i++)
                msum_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            order_reg <= order_next;
            count_reg <= count_next;
            qstep_reg <= qstep_next;
            sing_reg  <= sing_next;
            oidx_reg  <= oidx_next;
            psum_reg  <= psum_next;
            msum_reg  <= msum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        perm_reg <= perm_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        last_reg <= last_next;
        p_reg    <= p_next;
        k_reg    <= k_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        j_reg    <= j_next;
        best_reg <= best_next;
        bmag_reg <= bmag_next;
        dvb_reg  <= dvb_next;
        f_reg    <= f_next;
        s_reg    <= s_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        qneg_reg <= qneg_next;
        acc_reg  <= acc_next;
        qres_reg <= qres_next;
        if (mat_we)
            mat_reg[wr_row][wr_col] <= wr_data;
        if (coef_clr)
        begin
            for (int i = 0; i < plsf_pkg::NROW; i++)
                coef_reg[i] <= '0;
        end
        else if (coef_we)
        begin
            coef_reg[row_reg] <= div_quot;
        end
    end

    assign result_valid             = (state_reg == S_OUT);
    assign result_data.coef_index   = oidx_reg;
    assign result_data.coefficient  = coef_reg[oidx_reg];
    assign result_data.singular     = sing_reg;
    assign result_data.last_coef    = (oidx_reg == n);

`ifndef NO_ASSERTIONS
    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(plsf_pkg::MAX_POINTS))
        else $error("point count beyond limit");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.singular |-> result_data.coefficient == '0)
        else $error("singular run gave a nonzero coefficient");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result_data.last_coef |=> state_reg == S_IDLE)
        else $error("no return to idle after final transfer");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> count_reg == '0)
        else $error("sums not cleared before results");
`endif

endmodule

### design/plsf_mul.sv
// ----------------------------------------------------------------------------
// plsf_mul
// shared signed 33x33 multiplier with registered product
// ----------------------------------------------------------------------------
module plsf_mul (
    input  logic                               clk,
    input  logic signed [plsf_pkg::MUL_W-1:0]  a,
    input  logic signed [plsf_pkg::MUL_W-1:0]  b,
    output logic signed [plsf_pkg::PROD_W-1:0] prod
);

    logic signed [plsf_pkg::PROD_W-1:0] prod_reg;
    logic signed [plsf_pkg::PROD_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### design/plsf_div.sv
// ----------------------------------------------------------------------------
// plsf_div
// bit-serial Q32.32 divider, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module plsf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [63:0]               a,
    input  logic [63:0]               b,
    output plsf_pkg::div_stat_t       stat,
    output logic [63:0]               quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [plsf_pkg::DSTEP_W-1:0]      cnt_reg, cnt_next;
    logic [95:0]                       num_reg, num_next;
    logic [63:0]                       rem_reg, rem_next;
    logic [63:0]                       q_reg, q_next;
    logic                              over_reg, over_next;
    logic [63:0]                       d_reg, d_next;
    logic                              neg_reg, neg_next;
    logic [63:0]                       quot_reg, quot_next;
    logic [64:0]                       trial;
    logic                              qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, num_reg[95]};
        qbit      = (trial >= {1'b0, d_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {plsf_pkg::mag64(a), 32'd0};
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            d_next    = plsf_pkg::mag64(b);
            neg_next  = a[63] ^ b[63];
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[94:0], 1'b0};
            rem_next  = qbit ? 64'(trial - {1'b0, d_reg}) : trial[63:0];
            q_next    = {q_reg[62:0], qbit};
            over_next = over_reg | q_reg[63];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == plsf_pkg::DSTEP_W'(plsf_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = plsf_pkg::from_mag(over_next ? 64'hFFFF_FFFF_FFFF_FFFF : q_next,
                                               neg_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

### bench/plsf_checker.sv
// ----------------------------------------------------------------------------
// plsf_checker
// watches the sample, result and register ports of the polynomial fit block,
// predicts every coefficient in fixed point and compares each result transfer
// ----------------------------------------------------------------------------
module plsf_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic                           sample_stall,
    input  plsf_pkg::sample_t              sample_data,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  plsf_pkg::result_t              result_data,
    input  logic                           cfg_wr_en,
    input  logic [plsf_pkg::ORD_W-1:0]     cfg_wr_data,
    output int                             error_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SAT_LO = 64'sh8000_0000_0000_0000;

    longint                     power_acc [plsf_pkg::NPOW];
    longint                     moment_acc [plsf_pkg::NROW];
    int unsigned                points_taken;
    logic [plsf_pkg::ORD_W-1:0] fit_order;
    plsf_pkg::result_t          coef_queue [$];

    function automatic logic [63:0] abs_of(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(input logic [63:0] m, input bit neg);
        if (neg)
            return m[63] ? SAT_LO : -longint'(m);
        return m[63] ? SAT_HI : longint'(m);
    endfunction

    function automatic longint add_clip(input longint a, input longint b);
        longint r;
        r = a + b;
        if (a >= 0 && b >= 0 && r < 0)
            return SAT_HI;
        if (a < 0 && b < 0 && r >= 0)
            return SAT_LO;
        return r;
    endfunction

    function automatic longint sub_clip(input longint a, input longint b);
        longint r;
        r = a - b;
        if (a >= 0 && b < 0 && r < 0)
            return SAT_HI;
        if (a < 0 && b >= 0 && r >= 0)
            return SAT_LO;
        return r;
    endfunction

    // Q32.32 product, rounded half away from zero
    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
        p = (p + 128'd2147483648) >> 32;
        if (p[127:64] != 0)
            p[63:0] = '1;
        return signed_of(p[63:0], (a < 0) != (b < 0));
    endfunction

    // Q32.32 quotient, truncated toward zero
    function automatic longint q_div(input longint a, input longint b);
        logic [127:0] q;
        q = ({64'd0, abs_of(a)} << 32) / {64'd0, abs_of(b)};
        if (q[127:64] != 0)
            q[63:0] = '1;
        return signed_of(q[63:0], (a < 0) != (b < 0));
    endfunction

    task automatic absorb_point(input plsf_pkg::sample_t s);
        longint             x;
        longint             y;
        longint             p;
        longint             wm [plsf_pkg::NROW][plsf_pkg::NCOL];
        longint             coef [plsf_pkg::NROW];
        longint             acc;
        longint             f;
        int                 n;
        int                 best;
        bit                 singular;
        plsf_pkg::result_t  r;
        x = longint'(s.x_value);
        y = longint'(s.y_value);
        singular = 0;
        if (points_taken < plsf_pkg::MAX_POINTS)
        begin
            p = 8192;
            for (int k = 0; k < plsf_pkg::NPOW; k++)
            begin
                if (k > 0)
                    p = (p * x + 4096) >>> 13;
                power_acc[k] = add_clip(power_acc[k], p * 524288);
                if (k <= plsf_pkg::MAX_ORDER)
                    moment_acc[k] = add_clip(moment_acc[k], y * p * 2048);
            end
            points_taken++;
        end
        if (!s.last_point)
            return;

        n = (fit_order > plsf_pkg::MAX_ORDER) ? plsf_pkg::MAX_ORDER : int'(fit_order);
        for (int i = 0; i <= n; i++)
        begin
            for (int j = 0; j <= n; j++)
                wm[i][j] = power_acc[i + j];
            wm[i][n + 1] = moment_acc[i];
        end

        for (int c = 0; c <= n && !singular; c++)
        begin
            best = c;
            for (int i = c + 1; i <= n; i++)
                if (abs_of(wm[i][c]) > abs_of(wm[best][c]))
                    best = i;
            if (wm[best][c] == 0)
                singular = 1;
            else
            begin
                if (best != c)
                    for (int j = 0; j <= n + 1; j++)
                    begin
                        acc = wm[c][j];
                        wm[c][j] = wm[best][j];
                        wm[best][j] = acc;
                    end
                for (int i = c + 1; i <= n; i++)
                begin
                    f = q_div(wm[i][c], wm[c][c]);
                    for (int j = c + 1; j <= n + 1; j++)
                        wm[i][j] = sub_clip(wm[i][j], q_mul(f, wm[c][j]));
                    wm[i][c] = 0;
                end
            end
        end

        for (int i = 0; i < plsf_pkg::NROW; i++)
            coef[i] = 0;
        if (!singular)
            for (int k = n; k >= 0; k--)
            begin
                acc = wm[k][n + 1];
                for (int j = k + 1; j <= n; j++)
                    acc = sub_clip(acc, q_mul(wm[k][j], coef[j]));
                coef[k] = q_div(acc, wm[k][k]);
            end

        for (int i = 0; i <= n; i++)
        begin
            r.coef_index  = i[1:0];
            r.coefficient = coef[i];
            r.singular    = singular;
            r.last_coef   = (i == n);
            coef_queue.push_back(r);
        end
        for (int k = 0; k < plsf_pkg::NPOW; k++)
            power_acc[k] = 0;
        for (int k = 0; k < plsf_pkg::NROW; k++)
            moment_acc[k] = 0;
        points_taken = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        plsf_pkg::result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < plsf_pkg::NPOW; k++)
                power_acc[k] = 0;
            for (int k = 0; k < plsf_pkg::NROW; k++)
                moment_acc[k] = 0;
            points_taken = 0;
            fit_order = 1;
            coef_queue.delete();
            error_count = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (coef_queue.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: result transfer with none expected: %p", $time,
                                 result_data);
                    error_count++;
                end
                else
                begin
                    want = coef_queue.pop_front();
                    if (result_data.coef_index !== want.coef_index ||
                        result_data.coefficient !== want.coefficient ||
                        result_data.singular !== want.singular ||
                        result_data.last_coef !== want.last_coef)
                    begin
                        if (error_count < 10)
                            $display("%0t: coefficient mismatch, expected %p, got %p",
                                     $time, want, result_data);
                        error_count++;
                    end
                end
            end
            if (cfg_wr_en)
                fit_order = cfg_wr_data;
            if (sample_valid && !sample_stall)
                absorb_point(sample_data);
            pending = coef_queue.size();
        end
    end

endmodule

### bench/polynomial_least_squares_fit_tb.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_tb
// drives point sets at several fit orders, with random gaps and stalls,
// and gives the verdict from the checker's error and pending counts
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic                       clk = 0;
    logic                       rst_n = 0;
    logic                       sample_valid = 0;
    logic                       sample_stall;
    plsf_pkg::sample_t          sample_data = '0;
    logic                       result_valid;
    logic                       result_stall = 0;
    plsf_pkg::result_t          result_data;
    logic                       cfg_wr_en = 0;
    logic [plsf_pkg::ORD_W-1:0] cfg_wr_data = '0;
    int                         error_count;
    int                         pending;
    int                         cycle_count = 0;
    bit                         steady = 0;
    logic signed [15:0]         last_x = 0;

    always #2 clk = ~clk;

    polynomial_least_squares_fit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    plsf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .error_count  (error_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        result_stall <= !steady && ($urandom_range(99) < 15);

    // one point transfer; valid stays high afterwards until the next call or a drain
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic mark);
        if (!steady && $urandom_range(99) < 15)
        begin
            sample_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_valid <= 1;
        sample_data  <= '{x_value: x, y_value: y, last_point: mark};
        forever
        begin
            @(negedge clk);
            if (!sample_stall)
                break;
        end
        @(posedge clk);
    endtask

    // sender holds off until every coefficient is back and the block is quiet
    task automatic drain;
        sample_valid <= 0;
        forever
        begin
            @(negedge clk);
            if (pending == 0)
                break;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_order(input logic [plsf_pkg::ORD_W-1:0] v);
        drain();
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 0;
    endtask

    function automatic logic signed [15:0] pick_x;
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return $signed(16'($urandom_range(8192))) - 16'sd4096;
            2: return last_x;
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] x;
        int set_len;
        int sent;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // order 1 after reset: one point at the origin leaves a zero pivot
        send_point(0, 0, 1);
        send_point(16'sh7FFF, 16'sh7FFF, 0);
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(8192, 256, 1);
        send_point(4096, -512, 0);
        send_point(4096, 768, 1);
        write_order(2'd0);
        send_point(16'sh8000, 16'sh7FFF, 1);
        send_point(1, -1, 0);
        send_point(-1, 1, 1);
        write_order(2'd3);
        send_point(16'sh8000, 100, 0);
        send_point(-8192, -3000, 0);
        send_point(0, 16'sh8000, 0);
        send_point(8192, 5, 0);
        send_point(16'sh7FFF, 16'sh7FFF, 1);
        send_point(2000, 9, 0);
        send_point(-2000, 9, 1);
        write_order(2'd2);
        for (int i = 0; i < 5; i++)
            send_point(16'(i * 3000 - 6000), 16'(i * i * 300), i == 4);
        drain();

        sent = 0;
        while (sent < 255)
        begin
            steady = (sent >= 80 && sent < 140);
            if ($urandom_range(3) == 0)
                write_order(plsf_pkg::ORD_W'($urandom_range(3)));
            set_len = $urandom_range(1, 8);
            for (int i = 0; i < set_len; i++)
            begin
                x = pick_x();
                last_x = x;
                send_point(x, ($urandom_range(1) != 0) ? 16'($urandom_range(65535))
                                                       : 16'($urandom_range(2048)) - 16'sd1024,
                           i == set_len - 1);
                sent++;
            end
        end
        steady = 0;

        drain();
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
